// ===== hw/rtl/afv_pkg.sv =====
// Package for the airflow frame to velocity block: status codes, field widths,
// calibration tables and the structs passed between pipeline sections.
// No dependencies.
package afv_pkg;

  localparam int unsigned RawW     = 12;
  localparam int unsigned VelW     = 14;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned DvW      = 11;  // largest velocity step is 2000
  localparam int unsigned DxW      = 10;  // offset never exceeds the widest span (794)
  localparam int unsigned SpanW    = 10;
  localparam int unsigned RecipW   = 15;
  localparam int unsigned ProdW    = 21;
  localparam int unsigned QuotW    = 11;
  localparam int unsigned RemW     = 11;  // remainder stays below twice the span
  localparam int unsigned RecipSh  = 21;
  localparam int unsigned LvlW     = 4;
  localparam int unsigned TblPts   = 13;
  localparam int unsigned TblSegs  = 12;
  localparam int unsigned Model0Segs = 8;
  localparam int unsigned Model1Segs = 12;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusChecksum = 2'd1;
  localparam logic [StatusW-1:0] StatusRange    = 2'd2;

  localparam logic [VelW-1:0] VelMax = 14'd15000;

  // Breakpoints (raw reading) per model.
  localparam logic [RawW-1:0] AdcTbl [2][TblPts] = '{
    '{12'd409, 12'd915, 12'd1522, 12'd2066, 12'd2523, 12'd2908, 12'd3256,
      12'd3572, 12'd3686, 12'd3686, 12'd3686, 12'd3686, 12'd3686},
    '{12'd409, 12'd1203, 12'd1597, 12'd1908, 12'd2187, 12'd2400, 12'd2629,
      12'd2801, 12'd3006, 12'd3178, 12'd3309, 12'd3563, 12'd3686}
  };

  // Velocity in mm/s at each breakpoint.
  localparam logic [VelW-1:0] VelTbl [2][TblPts] = '{
    '{14'd0, 14'd1070, 14'd2010, 14'd3000, 14'd3970, 14'd4960, 14'd5980,
      14'd6990, 14'd7230, 14'd7230, 14'd7230, 14'd7230, 14'd7230},
    '{14'd0, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000, 14'd7000,
      14'd8000, 14'd9000, 14'd10000, 14'd11000, 14'd13000, 14'd15000}
  };

  // floor(2^21 / span) for each segment; zero where the span is zero.
  localparam logic [RecipW-1:0] RecipTbl [2][TblSegs] = '{
    '{15'd4144, 15'd3454, 15'd3855, 15'd4588, 15'd5447, 15'd6026, 15'd6636,
      15'd18396, 15'd0, 15'd0, 15'd0, 15'd0},
    '{15'd2641, 15'd5322, 15'd6743, 15'd7516, 15'd9845, 15'd9157, 15'd12192,
      15'd10230, 15'd12192, 15'd16008, 15'd8256, 15'd17050}
  };

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [RawW-1:0]    raw;
    logic [VelW-1:0]    base;
    logic [DvW-1:0]     dv;
    logic [DxW-1:0]     dx;
    logic [SpanW-1:0]   span;
    logic [RecipW-1:0]  recip;
  } seg_t;

  typedef struct packed {
    logic [VelW-1:0]    velocity;
    logic [StatusW-1:0] status;
    logic [RawW-1:0]    raw;
  } result_t;

endpackage

// ===== hw/rtl/afv_locate.sv =====
// Front section: checksum, breakpoint compares and segment table fetch (two stages).
// Depends on afv_pkg.
module afv_locate #(
  parameter int unsigned MAX_SEGMENTS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       model_i,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [7:0]                 check_byte_i,
  input  logic [7:0]                 raw_high_i,
  input  logic [7:0]                 raw_low_i,
  input  logic [7:0]                 spare_high_i,
  input  logic [7:0]                 spare_low_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output afv_pkg::seg_t              seg_o
);

  localparam int unsigned CmpCnt =
      (MAX_SEGMENTS > afv_pkg::TblSegs) ? afv_pkg::TblSegs : MAX_SEGMENTS;
  localparam logic [afv_pkg::LvlW-1:0] NsegM0 =
      afv_pkg::LvlW'((afv_pkg::Model0Segs > CmpCnt) ? CmpCnt : afv_pkg::Model0Segs);
  localparam logic [afv_pkg::LvlW-1:0] NsegM1 =
      afv_pkg::LvlW'((afv_pkg::Model1Segs > CmpCnt) ? CmpCnt : afv_pkg::Model1Segs);

  // Stage 1 registers
  logic                          s1_v_q;
  logic [afv_pkg::StatusW-1:0]   s1_status_q, s1_status_d;
  logic [afv_pkg::RawW-1:0]      s1_raw_q, s1_raw_d;
  logic [CmpCnt-1:0]             s1_gt_q, s1_gt_d;
  logic                          s1_model_q;

  // Stage 2 registers
  logic                          s2_v_q;
  afv_pkg::seg_t                 s2_q, s2_d;

  logic rdy1, rdy2;

  assign rdy2    = !s2_v_q || !stall_i;
  assign rdy1    = !s1_v_q || rdy2;
  assign stall_o = !rdy1;
  assign valid_o = s2_v_q;
  assign seg_o   = s2_q;

  // Stage 1: checksum, range test and one compare per segment's lower breakpoint.
  always_comb begin
    logic [7:0]                 sum;
    logic [afv_pkg::LvlW-1:0]   nseg;
    logic                       out_of_range;
    sum = check_byte_i + raw_high_i + raw_low_i + spare_high_i + spare_low_i;
    s1_raw_d = {raw_high_i[3:0], raw_low_i};
    nseg = model_i ? NsegM1 : NsegM0;
    for (int k = 0; k < CmpCnt; k++) begin
      s1_gt_d[k] = (s1_raw_d > afv_pkg::AdcTbl[model_i][k]) &&
                   (afv_pkg::LvlW'(k) < nseg);
    end
    out_of_range = (s1_raw_d < afv_pkg::AdcTbl[model_i][0]) ||
                   (s1_raw_d > afv_pkg::AdcTbl[model_i][nseg]);
    if (sum != 8'd0) begin
      s1_status_d = afv_pkg::StatusChecksum;
    end else if (out_of_range) begin
      s1_status_d = afv_pkg::StatusRange;
    end else begin
      s1_status_d = afv_pkg::StatusOk;
    end
  end

  // Stage 2: pick the last breakpoint below the reading and fetch its segment.
  always_comb begin
    logic [afv_pkg::LvlW-1:0]   lvl;
    logic [afv_pkg::LvlW-1:0]   lvl_nx;
    logic [afv_pkg::RawW-1:0]   adc_lo, adc_hi, span_w, dx_w;
    logic [afv_pkg::VelW-1:0]   vel_lo, vel_hi, dv_w;
    lvl = '0;
    for (int k = 0; k < CmpCnt; k++) begin
      if (s1_gt_q[k]) begin
        lvl = afv_pkg::LvlW'(k);
      end
    end
    lvl_nx = lvl + afv_pkg::LvlW'(1);
    adc_lo = afv_pkg::AdcTbl[s1_model_q][lvl];
    adc_hi = afv_pkg::AdcTbl[s1_model_q][lvl_nx];
    vel_lo = afv_pkg::VelTbl[s1_model_q][lvl];
    vel_hi = afv_pkg::VelTbl[s1_model_q][lvl_nx];
    span_w = adc_hi - adc_lo;
    dx_w   = s1_raw_q - adc_lo;
    dv_w   = vel_hi - vel_lo;
    s2_d.status = s1_status_q;
    s2_d.raw    = s1_raw_q;
    s2_d.dv     = dv_w[afv_pkg::DvW-1:0];
    s2_d.span   = span_w[afv_pkg::SpanW-1:0];
    s2_d.recip  = afv_pkg::RecipTbl[s1_model_q][lvl];
    // An errored item carries zero base and offset, so it comes out as zero.
    if (s1_status_q == afv_pkg::StatusOk) begin
      s2_d.base = vel_lo;
      s2_d.dx   = dx_w[afv_pkg::DxW-1:0];
    end else begin
      s2_d.base = '0;
      s2_d.dx   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_q <= valid_i;
      end
      if (rdy2) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      s1_status_q <= s1_status_d;
      s1_raw_q    <= s1_raw_d;
      s1_gt_q     <= s1_gt_d;
      s1_model_q  <= model_i;
    end
    if (rdy2 && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

endmodule

// ===== hw/rtl/afv_interp.sv =====
// Interpolation section: offset multiply, reciprocal divide with one correction
// step and final add (four stages). Depends on afv_pkg.
module afv_interp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  afv_pkg::seg_t      seg_i,
  output logic               valid_o,
  input  logic               stall_i,
  output afv_pkg::result_t   result_o
);

  localparam int unsigned FullW = afv_pkg::ProdW + afv_pkg::RecipW;

  // Stage 3: product of velocity step and offset.
  logic                          s3_v_q;
  logic [afv_pkg::ProdW-1:0]     s3_prod_q;
  logic [afv_pkg::VelW-1:0]      s3_base_q;
  logic [afv_pkg::SpanW-1:0]     s3_span_q;
  logic [afv_pkg::RecipW-1:0]    s3_recip_q;
  logic [afv_pkg::StatusW-1:0]   s3_status_q;
  logic [afv_pkg::RawW-1:0]      s3_raw_q;

  // Stage 4: quotient estimate, at most one below the true quotient.
  logic                          s4_v_q;
  logic [afv_pkg::QuotW-1:0]     s4_quot_q;
  logic [afv_pkg::ProdW-1:0]     s4_prod_q;
  logic [afv_pkg::VelW-1:0]      s4_base_q;
  logic [afv_pkg::SpanW-1:0]     s4_span_q;
  logic [afv_pkg::StatusW-1:0]   s4_status_q;
  logic [afv_pkg::RawW-1:0]      s4_raw_q;

  // Stage 5: remainder of the estimate.
  logic                          s5_v_q;
  logic [afv_pkg::QuotW-1:0]     s5_quot_q;
  logic [afv_pkg::RemW-1:0]      s5_rem_q;
  logic [afv_pkg::VelW-1:0]      s5_base_q;
  logic [afv_pkg::SpanW-1:0]     s5_span_q;
  logic [afv_pkg::StatusW-1:0]   s5_status_q;
  logic [afv_pkg::RawW-1:0]      s5_raw_q;

  // Stage 6: output register.
  logic                          s6_v_q;
  afv_pkg::result_t              s6_q, s6_d;

  logic                          rdy3, rdy4, rdy5, rdy6;
  logic [afv_pkg::ProdW-1:0]     prod_d;
  logic [FullW-1:0]              full_w;
  logic [afv_pkg::ProdW-1:0]     qspan_w;
  logic [afv_pkg::ProdW-1:0]     rem_w;

  assign rdy6    = !s6_v_q || !stall_i;
  assign rdy5    = !s5_v_q || rdy6;
  assign rdy4    = !s4_v_q || rdy5;
  assign rdy3    = !s3_v_q || rdy4;
  assign stall_o = !rdy3;
  assign valid_o = s6_v_q;
  assign result_o = s6_q;

  assign prod_d  = afv_pkg::ProdW'(seg_i.dv) * afv_pkg::ProdW'(seg_i.dx);
  assign full_w  = FullW'(s3_prod_q) * FullW'(s3_recip_q);
  assign qspan_w = afv_pkg::ProdW'(s4_quot_q) * afv_pkg::ProdW'(s4_span_q);
  assign rem_w   = s4_prod_q - qspan_w;

  always_comb begin
    logic inc;
    inc = (s5_span_q != '0) && (s5_rem_q >= afv_pkg::RemW'(s5_span_q));
    s6_d.velocity = s5_base_q + afv_pkg::VelW'(s5_quot_q) + afv_pkg::VelW'(inc);
    s6_d.status   = s5_status_q;
    s6_d.raw      = s5_raw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (rdy3) begin
        s3_v_q <= valid_i;
      end
      if (rdy4) begin
        s4_v_q <= s3_v_q;
      end
      if (rdy5) begin
        s5_v_q <= s4_v_q;
      end
      if (rdy6) begin
        s6_v_q <= s5_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && valid_i) begin
      s3_prod_q   <= prod_d;
      s3_base_q   <= seg_i.base;
      s3_span_q   <= seg_i.span;
      s3_recip_q  <= seg_i.recip;
      s3_status_q <= seg_i.status;
      s3_raw_q    <= seg_i.raw;
    end
    if (rdy4 && s3_v_q) begin
      s4_quot_q   <= full_w[afv_pkg::RecipSh +: afv_pkg::QuotW];
      s4_prod_q   <= s3_prod_q;
      s4_base_q   <= s3_base_q;
      s4_span_q   <= s3_span_q;
      s4_status_q <= s3_status_q;
      s4_raw_q    <= s3_raw_q;
    end
    if (rdy5 && s4_v_q) begin
      s5_quot_q   <= s4_quot_q;
      s5_rem_q    <= rem_w[afv_pkg::RemW-1:0];
      s5_base_q   <= s4_base_q;
      s5_span_q   <= s4_span_q;
      s5_status_q <= s4_status_q;
      s5_raw_q    <= s4_raw_q;
    end
    if (rdy6 && s5_v_q) begin
      s6_q <= s6_d;
    end
  end

endmodule

// ===== hw/rtl/airflow_frame_to_velocity.sv =====
// Airflow frame to velocity: sensor frame checksum, calibration lookup and
// linear interpolation. Uses afv_pkg, afv_locate and afv_interp.
// Throughput is one item per cycle; the six-stage pipeline only holds when the
// output register is stalled and every stage is full.
// Reset clears all stage valid bits and sets the device model to 0.
module airflow_frame_to_velocity #(
  parameter int unsigned MAX_SEGMENTS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [7:0]                   check_byte_i,
  input  logic [7:0]                   raw_high_i,
  input  logic [7:0]                   raw_low_i,
  input  logic [7:0]                   spare_high_i,
  input  logic [7:0]                   spare_low_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [afv_pkg::VelW-1:0]     velocity_mm_s_o,
  output logic [afv_pkg::StatusW-1:0]  status_o,
  output logic [afv_pkg::RawW-1:0]     raw_reading_o
);

  logic              device_model_q;
  logic              mid_valid;
  logic              mid_stall;
  afv_pkg::seg_t     mid_seg;
  afv_pkg::result_t  result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_model_q <= 1'b0;
    end else if (cfg_we_i) begin
      device_model_q <= cfg_wdata_i;
    end
  end

  afv_locate #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_locate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .model_i      (device_model_q),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .check_byte_i (check_byte_i),
    .raw_high_i   (raw_high_i),
    .raw_low_i    (raw_low_i),
    .spare_high_i (spare_high_i),
    .spare_low_i  (spare_low_i),
    .valid_o      (mid_valid),
    .stall_i      (mid_stall),
    .seg_o        (mid_seg)
  );

  afv_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mid_valid),
    .stall_o  (mid_stall),
    .seg_i    (mid_seg),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .result_o (result)
  );

  assign velocity_mm_s_o = result.velocity;
  assign status_o        = result.status;
  assign raw_reading_o   = result.raw;

  // An errored item always reports zero velocity.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != afv_pkg::StatusOk)) |-> (velocity_mm_s_o == '0))
    else $error("errored item with nonzero velocity");

  // A valid item never exceeds the top of the larger table.
  a_vel_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == afv_pkg::StatusOk)) |-> (velocity_mm_s_o <= afv_pkg::VelMax))
    else $error("velocity above calibration range");

  // The input side only stalls when the output holds a result that is not taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled while the output can move");

endmodule

// ===== test/afv_frame_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the airflow frame to velocity block: it predicts each result
// from the accepted frame and the selected table, then compares it with the output.
// Depends on afv_pkg for field widths and status codes.
module afv_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         frame_valid_i,
  input  logic                         frame_stall_i,
  input  logic [7:0]                   check_byte_i,
  input  logic [7:0]                   raw_high_i,
  input  logic [7:0]                   raw_low_i,
  input  logic [7:0]                   spare_high_i,
  input  logic [7:0]                   spare_low_i,
  input  logic                         result_valid_i,
  input  logic                         result_stall_i,
  input  logic [afv_pkg::VelW-1:0]     velocity_i,
  input  logic [afv_pkg::StatusW-1:0]  status_i,
  input  logic [afv_pkg::RawW-1:0]     raw_reading_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o,
  output int unsigned                  bad_sum_o,
  output int unsigned                  out_of_range_o
);

  localparam int unsigned MaxSegments = 12;

  // Calibration breakpoints and velocities, one row per sensor model.
  localparam int unsigned CalAdc [2][13] = '{
    '{409, 915, 1522, 2066, 2523, 2908, 3256, 3572, 3686, 3686, 3686, 3686, 3686},
    '{409, 1203, 1597, 1908, 2187, 2400, 2629, 2801, 3006, 3178, 3309, 3563, 3686}
  };
  localparam int unsigned CalVel [2][13] = '{
    '{0, 1070, 2010, 3000, 3970, 4960, 5980, 6990, 7230, 7230, 7230, 7230, 7230},
    '{0, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000, 11000, 13000, 15000}
  };

  typedef struct packed {
    logic [afv_pkg::VelW-1:0]    velocity;
    logic [afv_pkg::StatusW-1:0] status;
    logic [afv_pkg::RawW-1:0]    raw;
  } reading_t;

  reading_t expected_q [$];
  bit       table_model;

  function automatic reading_t convert_frame(input bit model, input logic [7:0] b0,
                                             input logic [7:0] b1, input logic [7:0] b2,
                                             input logic [7:0] b3, input logic [7:0] b4);
    int unsigned sum;
    int unsigned raw;
    int unsigned segs;
    int unsigned lvl;
    int unsigned span;
    int unsigned gain;
    int unsigned vel;
    reading_t    r;
    sum  = (b0 + b1 + b2 + b3 + b4) & 32'hFF;
    raw  = {b1[3:0], b2};
    segs = model ? 12 : 8;
    if (segs > MaxSegments) segs = MaxSegments;
    lvl  = 0;
    vel  = 0;
    r.raw    = raw[afv_pkg::RawW-1:0];
    r.status = afv_pkg::StatusOk;
    if (sum != 0) begin
      r.status = afv_pkg::StatusChecksum;
    end else if (raw < CalAdc[model][0] || raw > CalAdc[model][segs]) begin
      r.status = afv_pkg::StatusRange;
    end else begin
      // The segment is the last breakpoint lying strictly below the reading.
      for (int k = 0; k < segs; k++) begin
        if (raw > CalAdc[model][k]) lvl = k;
      end
      span = CalAdc[model][lvl+1] - CalAdc[model][lvl];
      gain = CalVel[model][lvl+1] - CalVel[model][lvl];
      vel  = CalVel[model][lvl];
      if (span != 0) vel += gain * (raw - CalAdc[model][lvl]) / span;
    end
    r.velocity = vel[afv_pkg::VelW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reading_t want;
    reading_t got;
    if (!rst_ni) begin
      table_model = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) table_model = cfg_wdata_i;
      if (result_valid_i && !result_stall_i) begin
        got = '{velocity: velocity_i, status: status_i, raw: raw_reading_i};
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("%0t: result with nothing expected: vel %0d status %0d raw %0d",
                     $time, got.velocity, got.status, got.raw);
          end
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.status == afv_pkg::StatusChecksum) bad_sum_o <= bad_sum_o + 1;
          if (want.status == afv_pkg::StatusRange) out_of_range_o <= out_of_range_o + 1;
          if (got.velocity !== want.velocity || got.status !== want.status ||
              got.raw !== want.raw) begin
            if (mismatches_o < 10) begin
              $display({"%0t: mismatch: expected vel %0d status %0d raw %0d,",
                        " got vel %0d status %0d raw %0d"},
                       $time, want.velocity, want.status, want.raw,
                       got.velocity, got.status, got.raw);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (frame_valid_i && !frame_stall_i) begin
        expected_q.push_back(convert_frame(table_model, check_byte_i, raw_high_i, raw_low_i,
                                           spare_high_i, spare_low_i));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the airflow frame to velocity testbench: clock, reset, frame stimulus,
// output stalls and the verdict. Depends on afv_pkg, afv_frame_checker and the block.
module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;

  // Breakpoints of both tables, used to aim readings at segment edges.
  localparam int unsigned Knees [20] = '{
    409, 915, 1203, 1522, 1597, 1908, 2066, 2187, 2400, 2523,
    2629, 2801, 2908, 3006, 3178, 3256, 3309, 3563, 3572, 3686
  };

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic                        cfg_wdata;
  logic                        frame_valid;
  logic                        frame_stall;
  logic [7:0]                  check_byte;
  logic [7:0]                  raw_high;
  logic [7:0]                  raw_low;
  logic [7:0]                  spare_high;
  logic [7:0]                  spare_low;
  logic                        result_valid;
  logic                        result_stall;
  logic [afv_pkg::VelW-1:0]    velocity;
  logic [afv_pkg::StatusW-1:0] status;
  logic [afv_pkg::RawW-1:0]    raw_reading;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned bad_sums;
  int unsigned out_of_range;
  int unsigned cycles;
  int unsigned frames_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned holds_asked;
  int unsigned holds_done;

  airflow_frame_to_velocity dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .valid_i         (frame_valid),
    .stall_o         (frame_stall),
    .check_byte_i    (check_byte),
    .raw_high_i      (raw_high),
    .raw_low_i       (raw_low),
    .spare_high_i    (spare_high),
    .spare_low_i     (spare_low),
    .valid_o         (result_valid),
    .stall_i         (result_stall),
    .velocity_mm_s_o (velocity),
    .status_o        (status),
    .raw_reading_o   (raw_reading)
  );

  afv_frame_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .frame_valid_i  (frame_valid),
    .frame_stall_i  (frame_stall),
    .check_byte_i   (check_byte),
    .raw_high_i     (raw_high),
    .raw_low_i      (raw_low),
    .spare_high_i   (spare_high),
    .spare_low_i    (spare_low),
    .result_valid_i (result_valid),
    .result_stall_i (result_stall),
    .velocity_i     (velocity),
    .status_i       (status),
    .raw_reading_i  (raw_reading),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .bad_sum_o      (bad_sums),
    .out_of_range_o (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("TEST FAILED");
    $finish;
  end

  // Output side: random stalls, or a long hold-off when one is requested.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        result_stall <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk);
        holds_done++;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic offer_frame(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] b4);
    while ($urandom_range(99) < gap_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    check_byte  <= b0;
    raw_high    <= b1;
    raw_low     <= b2;
    spare_high  <= b3;
    spare_low   <= b4;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    frames_sent++;
  endtask

  // Builds a frame around a 12-bit reading; the check byte makes the sum zero
  // unless the frame is meant to be corrupt.
  task automatic offer_reading(input int unsigned raw, input bit corrupt);
    logic [7:0] hi;
    logic [7:0] sh;
    logic [7:0] sl;
    logic [7:0] chk;
    hi  = {4'($urandom), raw[11:8]};
    sh  = 8'($urandom);
    sl  = 8'($urandom);
    chk = 8'h00 - hi - raw[7:0] - sh - sl;
    if (corrupt) chk = chk + 8'($urandom_range(255, 1));
    offer_frame(chk, hi, raw[7:0], sh, sl);
  endtask

  task automatic offer_random_readings(input int unsigned count);
    int unsigned pick;
    int unsigned raw;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 15) raw = $urandom_range(4095);
      else if (pick < 40) raw = Knees[$urandom_range(19)] + $urandom_range(4) - 2;
      else raw = $urandom_range(3686, 409);
      offer_reading(raw, $urandom_range(99) < 10);
    end
  endtask

  task automatic drain();
    frame_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_model(input bit model);
    cfg_we    <= 1'b1;
    cfg_wdata <= model;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned m0_raws [10];
    int unsigned m1_raws [7];
    m0_raws = '{408, 409, 410, 915, 1000, 3572, 3685, 3686, 3687, 4095};
    m1_raws = '{409, 1203, 1204, 3563, 3600, 3686, 3687};
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    frame_valid = 1'b0;
    check_byte  = '0;
    raw_high    = '0;
    raw_low     = '0;
    spare_high  = '0;
    spare_low   = '0;
    gap_pct     = 8;
    stall_pct   = 79;
    holds_asked = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames for the 7 m/s table: range ends, breakpoints, bad sums.
    set_model(1'b0);
    foreach (m0_raws[i]) offer_reading(m0_raws[i], 1'b0);
    offer_reading(2000, 1'b1);
    offer_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_frame(8'h8E, 8'h0E, 8'h66, 8'hFF, 8'hFF);
    drain();

    // Directed frames for the 15 m/s table; a bad sum skips the range test.
    set_model(1'b1);
    foreach (m1_raws[i]) offer_reading(m1_raws[i], 1'b0);
    offer_reading(4095, 1'b1);
    offer_random_readings(150);
    drain();

    set_model(1'b0);
    gap_pct   = 79;
    stall_pct = 8;
    offer_random_readings(150);
    drain();

    // Back to back, with one long output hold-off so the pipeline fills up.
    set_model(1'b1);
    gap_pct   = 0;
    stall_pct = 0;
    holds_asked++;
    offer_random_readings(140);
    drain();

    $display("Ran %0d frames through both calibration tables under three idle mixes.",
             frames_sent);
    $display("Checked %0d results: %0d bad checksums, %0d readings out of range.",
             checked, bad_sums, out_of_range);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/afv_pkg.sv
hw/rtl/afv_locate.sv
hw/rtl/afv_interp.sv
hw/rtl/airflow_frame_to_velocity.sv
test/afv_frame_checker.sv
test/testbench.sv
